// ===== design/mhl_pkg.sv =====
// Shared constants and types for the Maidenhead locator converter.
package mhl_pkg;

	// Point to locator: half spans in seconds and the last valid offset count
	localparam logic [19:0] LonHalf = 20'd648000;
	localparam logic [20:0] LonLast = 21'd1295999;
	localparam logic [18:0] LatHalf = 19'd324000;
	localparam logic [19:0] LatLast = 20'd647999;

	// floor(y / 75) = (y * Recip75) >> 25, exact for y < 780335
	localparam logic [18:0] Recip75 = 19'd447393;
	// floor(x / 3) = (x * Div3Mul) >> 11 for x < 2048
	localparam logic [9:0]  Div3Mul = 10'd683;
	// floor(x / 10) = (x * Div10Mul) >> 11 for x < 1029
	localparam logic [7:0]  Div10Mul = 8'd205;

	// Subsquare count from the west or south edge to the equator or meridian
	localparam logic [12:0] CenterCnt = 13'd2160;

	localparam logic [4:0]  FieldMax = 5'd17;
	localparam logic [4:0]  SubMax   = 5'd23;

	localparam logic [7:0]  ChUpA  = 8'h41;
	localparam logic [7:0]  ChLowA = 8'h61;
	localparam logic [7:0]  ChLowZ = 8'h7a;
	localparam logic [7:0]  ChZero = 8'h30;
	localparam logic [7:0]  ChNine = 8'h39;
	localparam logic [7:0]  ChUpL  = 8'h4c;

	// Seconds of a subsquare centre
	localparam logic [5:0]  LonCtrSec = 6'd30;
	localparam logic [5:0]  LatSecLo  = 6'd15;
	localparam logic [5:0]  LatSecHi  = 6'd45;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} mhl_ctl_t;

endpackage

// ===== design/mhl_point.sv =====
// Point to locator datapath: five register stages from DMS to six ASCII characters.
module mhl_point import mhl_pkg::*; (
	input  logic        clk,
	input  mhl_ctl_t    ctl,
	input  logic [6:0]  lat_deg,
	input  logic [5:0]  lat_min,
	input  logic [5:0]  lat_sec,
	input  logic        lat_south,
	input  logic [7:0]  lon_deg,
	input  logic [5:0]  lon_min,
	input  logic [5:0]  lon_sec,
	input  logic        lon_west,
	output logic [47:0] grid
);

	// stage 1: whole seconds, offset from the west / south edge, saturated
	logic [19:0] lon_mag, lat_mag;
	logic [20:0] lon_pos;
	logic [19:0] lat_pos;
	logic [20:0] u_s1;
	logic [19:0] v_s1;

	assign lon_mag = 20'(lon_deg) * 20'd3600 + 20'(lon_min) * 20'd60 + 20'(lon_sec);
	assign lat_mag = 20'(lat_deg) * 20'd3600 + 20'(lat_min) * 20'd60 + 20'(lat_sec);

	always_comb begin
		if (lon_west) begin
			lon_pos = (lon_mag >= LonHalf) ? '0 : 21'(LonHalf - lon_mag);
		end else begin
			lon_pos = (lon_mag >= LonHalf) ? LonLast : 21'(LonHalf) + 21'(lon_mag);
		end
		if (lat_south) begin
			lat_pos = (lat_mag >= 20'(LatHalf)) ? '0 : 20'(LatHalf) - lat_mag;
		end else begin
			lat_pos = (lat_mag >= 20'(LatHalf)) ? LatLast : 20'(LatHalf) + lat_mag;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			u_s1 <= lon_pos;
			v_s1 <= lat_pos;
		end
	end

	// stage 2: subsquare count = u / 300 = (u >> 2) / 75, v / 150 = (v >> 1) / 75
	logic [37:0] lon_prod, lat_prod;
	logic [12:0] lon_w_s2, lat_w_s2;

	assign lon_prod = 38'(u_s1[20:2]) * 38'(Recip75);
	assign lat_prod = 38'(v_s1[19:1]) * 38'(Recip75);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			lon_w_s2 <= lon_prod[37:25];
			lat_w_s2 <= lat_prod[37:25];
		end
	end

	// stage 3: square count = w / 24 = (w >> 3) / 3
	logic [19:0] lon_tprod, lat_tprod;
	logic [7:0]  lon_t_s3, lat_t_s3;
	logic [12:0] lon_w_s3, lat_w_s3;

	assign lon_tprod = 20'(lon_w_s2[12:3]) * 20'(Div3Mul);
	assign lat_tprod = 20'(lat_w_s2[12:3]) * 20'(Div3Mul);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			lon_t_s3 <= lon_tprod[18:11];
			lat_t_s3 <= lat_tprod[18:11];
			lon_w_s3 <= lon_w_s2;
			lat_w_s3 <= lat_w_s2;
		end
	end

	// stage 4: field = t / 10, subsquare = w mod 24
	logic [15:0] lon_fprod, lat_fprod;
	logic [4:0]  lon_field_s4, lat_field_s4;
	logic [4:0]  lon_sub_s4, lat_sub_s4;
	logic [7:0]  lon_t_s4, lat_t_s4;

	assign lon_fprod = 16'(lon_t_s3) * 16'(Div10Mul);
	assign lat_fprod = 16'(lat_t_s3) * 16'(Div10Mul);

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			lon_field_s4 <= lon_fprod[15:11];
			lat_field_s4 <= lat_fprod[15:11];
			lon_sub_s4   <= 5'(lon_w_s3 - 13'(lon_t_s3) * 13'd24);
			lat_sub_s4   <= 5'(lat_w_s3 - 13'(lat_t_s3) * 13'd24);
			lon_t_s4     <= lon_t_s3;
			lat_t_s4     <= lat_t_s3;
		end
	end

	// stage 5: square digit = t mod 10, assemble characters
	logic [3:0] lon_sq, lat_sq;

	assign lon_sq = 4'(lon_t_s4 - 8'(lon_field_s4) * 8'd10);
	assign lat_sq = 4'(lat_t_s4 - 8'(lat_field_s4) * 8'd10);

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			grid <= {ChUpA + 8'(lon_field_s4), ChUpA + 8'(lat_field_s4),
				ChZero + 8'(lon_sq), ChZero + 8'(lat_sq),
				ChLowA + 8'(lon_sub_s4), ChLowA + 8'(lat_sub_s4)};
		end
	end

endmodule

// ===== design/mhl_grid.sv =====
// Locator to point datapath: class check and subsquare centre in sign-magnitude DMS.
module mhl_grid import mhl_pkg::*; (
	input  logic        clk,
	input  mhl_ctl_t    ctl,
	input  logic [47:0] grid_in,
	input  logic        grid_short,
	output logic [6:0]  lat_deg,
	output logic [5:0]  lat_min,
	output logic [5:0]  lat_sec,
	output logic        lat_south,
	output logic [7:0]  lon_deg,
	output logic [5:0]  lon_min,
	output logic [5:0]  lon_sec,
	output logic        lon_west,
	output logic        bad
);

	// {valid, index}; either case accepted
	function automatic logic [5:0] letter_code(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		if (lc >= ChLowA && lc <= ChLowZ) begin
			return {1'b1, 5'(lc - ChLowA)};
		end
		return '0;
	endfunction

	function automatic logic [4:0] digit_code(input logic [7:0] c);
		if (c >= ChZero && c <= ChNine) begin
			return {1'b1, 4'(c - ChZero)};
		end
		return '0;
	endfunction

	// stage 1: decode characters, check classes, subsquare count per axis
	logic [7:0]  c4, c5;
	logic [5:0]  lf, af, lx, ax;
	logic [4:0]  ls, as;
	logic        chk_bad;
	logic [12:0] lon_w_s1, lat_w_s1;
	logic        bad_s1;

	assign c4 = grid_short ? ChUpL : grid_in[15:8];
	assign c5 = grid_short ? ChUpL : grid_in[7:0];
	assign lf = letter_code(grid_in[47:40]);
	assign af = letter_code(grid_in[39:32]);
	assign ls = digit_code(grid_in[31:24]);
	assign as = digit_code(grid_in[23:16]);
	assign lx = letter_code(c4);
	assign ax = letter_code(c5);

	assign chk_bad = !lf[5] || lf[4:0] > FieldMax || !af[5] || af[4:0] > FieldMax ||
		!ls[4] || !as[4] || !lx[5] || lx[4:0] > SubMax || !ax[5] || ax[4:0] > SubMax;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			lon_w_s1 <= 13'(lf[4:0]) * 13'd240 + 13'(ls[3:0]) * 13'd24 + 13'(lx[4:0]);
			lat_w_s1 <= 13'(af[4:0]) * 13'd240 + 13'(as[3:0]) * 13'd24 + 13'(ax[4:0]);
			bad_s1   <= chk_bad;
		end
	end

	// stage 2: fold about the centre; |offset| = (2n+1) half subsquares
	logic [11:0] lon_n, lat_n;
	logic        lon_neg, lat_neg;
	logic [12:0] lon_m_s2, lat_m_s2;
	logic        lon_neg_s2, lat_neg_s2, bad_s2;

	always_comb begin
		lon_neg = lon_w_s1 < CenterCnt;
		lat_neg = lat_w_s1 < CenterCnt;
		lon_n = lon_neg ? 12'(CenterCnt - 13'd1 - lon_w_s1) : 12'(lon_w_s1 - CenterCnt);
		lat_n = lat_neg ? 12'(CenterCnt - 13'd1 - lat_w_s1) : 12'(lat_w_s1 - CenterCnt);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			lon_m_s2   <= {lon_n, 1'b1};
			lat_m_s2   <= {lat_n, 1'b1};
			lon_neg_s2 <= lon_neg;
			lat_neg_s2 <= lat_neg;
			bad_s2     <= bad_s1;
		end
	end

	// stage 3: degrees; lon = m / 24, lat = m / 48
	logic [19:0] lon_dprod, lat_dprod;
	logic [7:0]  lon_deg_s3;
	logic [6:0]  lat_deg_s3;
	logic [12:0] lon_m_s3, lat_m_s3;
	logic        lon_neg_s3, lat_neg_s3, bad_s3;

	assign lon_dprod = 20'(lon_m_s2[12:3]) * 20'(Div3Mul);
	assign lat_dprod = 20'(lat_m_s2[12:4]) * 20'(Div3Mul);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			lon_deg_s3 <= lon_dprod[18:11];
			lat_deg_s3 <= lat_dprod[17:11];
			lon_m_s3   <= lon_m_s2;
			lat_m_s3   <= lat_m_s2;
			lon_neg_s3 <= lon_neg_s2;
			lat_neg_s3 <= lat_neg_s2;
			bad_s3     <= bad_s2;
		end
	end

	// stage 4: minutes and seconds from the remainder, zero on a bad locator
	logic [4:0] lon_r;
	logic [5:0] lat_r;
	logic [5:0] lon_mn, lat_mn, lat_sc;
	logic [6:0] lat_deg_s4;
	logic [5:0] lat_min_s4, lat_sec_s4, lon_min_s4, lon_sec_s4;
	logic [7:0] lon_deg_s4;
	logic       lat_south_s4, lon_west_s4, bad_s4;

	always_comb begin
		lon_r  = 5'(lon_m_s3 - 13'(lon_deg_s3) * 13'd24);
		lat_r  = 6'(lat_m_s3 - 13'(lat_deg_s3) * 13'd48);
		lon_mn = 6'((7'(lon_r) * 7'd5) >> 1);
		lat_mn = 6'((8'(lat_r) * 8'd5) >> 2);
		lat_sc = lat_r[1] ? LatSecHi : LatSecLo;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			bad_s4       <= bad_s3;
			lat_deg_s4   <= bad_s3 ? '0 : lat_deg_s3;
			lat_min_s4   <= bad_s3 ? '0 : lat_mn;
			lat_sec_s4   <= bad_s3 ? '0 : lat_sc;
			lat_south_s4 <= !bad_s3 && lat_neg_s3;
			lon_deg_s4   <= bad_s3 ? '0 : lon_deg_s3;
			lon_min_s4   <= bad_s3 ? '0 : lon_mn;
			lon_sec_s4   <= bad_s3 ? '0 : LonCtrSec;
			lon_west_s4  <= !bad_s3 && lon_neg_s3;
		end
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			bad       <= bad_s4;
			lat_deg   <= lat_deg_s4;
			lat_min   <= lat_min_s4;
			lat_sec   <= lat_sec_s4;
			lat_south <= lat_south_s4;
			lon_deg   <= lon_deg_s4;
			lon_min   <= lon_min_s4;
			lon_sec   <= lon_sec_s4;
			lon_west  <= lon_west_s4;
		end
	end

endmodule

// ===== design/maidenhead_locator_convert.sv =====
// Top level of the Maidenhead locator converter: pipeline control and output select.
// Throughput: one beat per cycle while rsp_stall is low; each of the five stages loads when it is empty
// or its content moves on, so bubbles close up and a held result stalls nothing behind an empty stage.
// Reset (arst_n low) clears the stage valid bits only; datapath registers are not reset.
module maidenhead_locator_convert import mhl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        kind,
	input  logic [6:0]  lat_deg,
	input  logic [5:0]  lat_min,
	input  logic [5:0]  lat_sec,
	input  logic        lat_south,
	input  logic [7:0]  lon_deg,
	input  logic [5:0]  lon_min,
	input  logic [5:0]  lon_sec,
	input  logic        lon_west,
	input  logic [47:0] grid_in,
	input  logic        grid_short,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [47:0] grid_out,
	output logic [6:0]  out_lat_deg,
	output logic [5:0]  out_lat_min,
	output logic [5:0]  out_lat_sec,
	output logic        out_lat_south,
	output logic [7:0]  out_lon_deg,
	output logic [5:0]  out_lon_min,
	output logic [5:0]  out_lon_sec,
	output logic        out_lon_west,
	output logic        bad_grid
);

	logic     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic     kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic     rdy1, rdy2, rdy3, rdy4, rdy5;
	mhl_ctl_t ctl;

	// a stage takes a new beat when empty or when its beat moves on
	assign rdy5 = !vld_s5 || !rsp_stall;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign ctl.ld_s1 = rdy1;
	assign ctl.ld_s2 = rdy2;
	assign ctl.ld_s3 = rdy3;
	assign ctl.ld_s4 = rdy4;
	assign ctl.ld_s5 = rdy5;

	assign req_stall = !rdy1;
	assign rsp_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= req_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) kind_s1 <= kind;
		if (rdy2) kind_s2 <= kind_s1;
		if (rdy3) kind_s3 <= kind_s2;
		if (rdy4) kind_s4 <= kind_s3;
		if (rdy5) kind_s5 <= kind_s4;
	end

	logic [47:0] pt_grid;
	logic [6:0]  g_lat_deg;
	logic [5:0]  g_lat_min, g_lat_sec, g_lon_min, g_lon_sec;
	logic [7:0]  g_lon_deg;
	logic        g_lat_south, g_lon_west, g_bad;

	mhl_point u_point (
		.clk       (clk),
		.ctl       (ctl),
		.lat_deg   (lat_deg),
		.lat_min   (lat_min),
		.lat_sec   (lat_sec),
		.lat_south (lat_south),
		.lon_deg   (lon_deg),
		.lon_min   (lon_min),
		.lon_sec   (lon_sec),
		.lon_west  (lon_west),
		.grid      (pt_grid)
	);

	mhl_grid u_grid (
		.clk        (clk),
		.ctl        (ctl),
		.grid_in    (grid_in),
		.grid_short (grid_short),
		.lat_deg    (g_lat_deg),
		.lat_min    (g_lat_min),
		.lat_sec    (g_lat_sec),
		.lat_south  (g_lat_south),
		.lon_deg    (g_lon_deg),
		.lon_min    (g_lon_min),
		.lon_sec    (g_lon_sec),
		.lon_west   (g_lon_west),
		.bad        (g_bad)
	);

	// each mode zeroes the other mode's fields
	assign grid_out      = kind_s5 ? '0 : pt_grid;
	assign out_lat_deg   = kind_s5 ? g_lat_deg : '0;
	assign out_lat_min   = kind_s5 ? g_lat_min : '0;
	assign out_lat_sec   = kind_s5 ? g_lat_sec : '0;
	assign out_lat_south = kind_s5 && g_lat_south;
	assign out_lon_deg   = kind_s5 ? g_lon_deg : '0;
	assign out_lon_min   = kind_s5 ? g_lon_min : '0;
	assign out_lon_sec   = kind_s5 ? g_lon_sec : '0;
	assign out_lon_west  = kind_s5 && g_lon_west;
	assign bad_grid      = kind_s5 && g_bad;

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_s1)
		else $error("accepted beat did not reach stage 1");

	a_no_hold_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !vld_s5 |=> vld_s5)
		else $error("stage 4 beat held behind an empty output stage");

	a_point_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && grid_out != 48'd0 |-> !bad_grid && out_lat_deg == 7'd0 &&
		out_lon_deg == 8'd0 && !out_lat_south && !out_lon_west)
		else $error("point-mode result carries locator-mode fields");

	a_centre_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && grid_out == 48'd0 && !bad_grid |->
		out_lon_sec == 6'd30 && (out_lat_sec == 6'd15 || out_lat_sec == 6'd45))
		else $error("subsquare centre seconds out of pattern");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_grid |-> grid_out == 48'd0 && out_lat_min == 6'd0 &&
		out_lon_min == 6'd0 && out_lon_sec == 6'd0)
		else $error("bad locator result not cleared");

endmodule
